// ===== hdl/column_bump_allocator_assert.svh =====
// ---------------------------------------------------------------------------
// Column bump allocator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef COLUMN_BUMP_ALLOCATOR_ASSERT_SVH
`define COLUMN_BUMP_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/cba_pkg.sv =====
// ---------------------------------------------------------------------------
// Column bump allocator package
// Operation and status codes and the item that travels down the cell row.
// ---------------------------------------------------------------------------
package cba_pkg;

  // Widest column address the block supports, and the width of a range end.
  localparam int COL_W  = 16;
  localparam int SIZE_W = 10;
  localparam int END_W  = 18;

  typedef enum logic [2:0] {
    OP_ALLOC   = 3'd0,
    OP_DEALLOC = 3'd1,
    OP_QUERY   = 3'd2,
    OP_RELINQ  = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_PERMIT_GONE = 3'd1,
    ST_BAD_SIZE    = 3'd2,
    ST_SIZE_GREW   = 3'd3,
    ST_OVERFLOW    = 3'd4,
    ST_UNKNOWN     = 3'd5,
    ST_MISMATCH    = 3'd6,
    ST_FULL        = 3'd7
  } status_t;

  // One item on its way through the cells, with the flags gathered so far.
  typedef struct packed {
    logic              vld;
    logic              do_alloc;
    logic              do_dealloc;
    logic              do_query;
    logic              do_clear;
    logic [COL_W-1:0]  col;
    logic [SIZE_W-1:0] size;
    logic [END_W-1:0]  q_end;
    logic              q_valid;
    logic              f_base;
    logic              f_live;
    logic              f_any;
    logic              f_hit;
    logic              f_match;
  } tok_t;

endpackage

// ===== hdl/cba_cell.sv =====
// ---------------------------------------------------------------------------
// Column bump allocator table cell
// Holds one allocation entry, acts on the passing item and hands it on.
// ---------------------------------------------------------------------------
`include "column_bump_allocator_assert.svh"

module cba_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  cba_pkg::tok_t tok_i,
  output cba_pkg::tok_t tok_o
);

  logic [cba_pkg::COL_W-1:0]  start_r;
  logic [cba_pkg::SIZE_W-1:0] size_r;
  logic                       live_r;
  logic                       retired_r;
  cba_pkg::tok_t              tok_r;
  cba_pkg::tok_t              tok_nxt;

  logic                       used;
  logic                       base_hit;
  logic [cba_pkg::END_W-1:0]  span_end;
  logic                       covers;
  logic                       take;
  logic                       free;

  // Entry compares against the passing item.
  always_comb begin
    used     = live_r | retired_r;
    base_hit = live_r && (start_r == tok_i.col);
    span_end = cba_pkg::END_W'(start_r) + cba_pkg::END_W'(size_r);
    covers   = tok_i.q_valid && (tok_i.col >= start_r) && (tok_i.q_end <= span_end);
    take     = tok_i.vld && tok_i.do_alloc && !used;
    free     = tok_i.vld && tok_i.do_dealloc && base_hit && (size_r == tok_i.size);
  end

  // Gather flags into the item; an alloc is claimed by the first free cell.
  always_comb begin
    tok_nxt = tok_i;
    if (take) begin
      tok_nxt.do_alloc = 1'b0;
    end
    if (tok_i.vld && tok_i.do_dealloc && base_hit) begin
      tok_nxt.f_hit = 1'b1;
    end
    if (free) begin
      tok_nxt.f_match = 1'b1;
    end
    if (tok_i.vld && tok_i.do_query) begin
      tok_nxt.f_base = tok_i.f_base | base_hit;
      tok_nxt.f_live = tok_i.f_live | (live_r && covers);
      tok_nxt.f_any  = tok_i.f_any | (used && covers);
    end
  end

  // Entry flags and the item register towards the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r    <= 1'b0;
      retired_r <= 1'b0;
      tok_r     <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (tok_i.vld && tok_i.do_clear) begin
        live_r    <= 1'b0;
        retired_r <= 1'b0;
      end else if (take) begin
        live_r    <= 1'b1;
        retired_r <= 1'b0;
      end else if (free) begin
        live_r    <= 1'b0;
        retired_r <= 1'b1;
      end
    end
  end

  // Entry payload is written when an alloc claims this cell.
  always_ff @(posedge clk) begin
    if (take) begin
      start_r <= tok_i.col;
      size_r  <= tok_i.size;
    end
  end

  assign tok_o = tok_r;

  `CBA_ASSERT_SAME(a_cell_one_state, 1'b1, !(live_r && retired_r), "entry both live and retired")
  `CBA_ASSERT_NEXT(a_cell_hand_on, tok_i.vld, tok_o.vld, "item lost between cells")
  `CBA_ASSERT_NEXT(a_cell_take, take, live_r && !tok_o.do_alloc, "claimed entry not live")

endmodule

// ===== hdl/column_bump_allocator.sv =====
// ---------------------------------------------------------------------------
// Column bump allocator
// Bump pointer column allocator with a table of allocation entries.
// ---------------------------------------------------------------------------
// An item is taken at a rising edge where start is high and busy is low. It
// carries an op (alloc, dealloc, range query, relinquish, clear) with its
// size, address and word count. Exactly one result follows for each item,
// shown on the out_ ports for one cycle with out_valid high; the receiver
// cannot hold it off and must take it then.
// The entry table is a row of ENTRIES cells. The item is registered once and
// then passes one cell per clock, each cell checking and updating its entry;
// the result appears once it has left the last cell, and busy is low again
// in that same cycle. No new item is taken until then, whatever the op.
// Pointer, size limit, permit and counters live here and are settled at the
// accepting edge; the dealloc status and the live count of a dealloc are
// settled when the item leaves the row. Reset (and the clear op) empties
// the table, zeroes the bump pointer and restores the allocation permit;
// no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "column_bump_allocator_assert.svh"

module column_bump_allocator #(
  parameter int ENTRIES     = 16,
  parameter int COLUMN_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic [9:0]  in_size_cols,
  input  logic [31:0] in_address,
  input  logic [16:0] in_word_count,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [15:0] out_grant_col,
  output logic        out_in_live,
  output logic        out_in_any,
  output logic        out_is_live_base,
  output logic [4:0]  out_live_total,
  output logic        out_permit_gone
);

  localparam int BP_W  = COLUMN_BITS + 1;
  localparam int SUM_W = COLUMN_BITS + 2;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [SUM_W-1:0] COL_COUNT = SUM_W'(1) << COLUMN_BITS;

  // Scope state.
  logic                       flight_r, flight_nxt;
  logic [BP_W-1:0]            bump_r, bump_nxt;
  logic [9:0]                 last_r, last_nxt;
  logic                       relinq_r, relinq_nxt;
  logic [CNT_W-1:0]           used_r, used_nxt;
  logic [CNT_W-1:0]           live_r, live_nxt;
  cba_pkg::status_t           hold_status_r, hold_status_nxt;
  logic [15:0]                hold_base_r, hold_base_nxt;
  cba_pkg::tok_t              inj_r, inj_nxt;

  // Result registers.
  logic                       out_valid_r;
  cba_pkg::status_t           out_status_r, out_status_nxt;
  logic [15:0]                out_base_r;
  logic                       out_in_live_r;
  logic                       out_in_any_r;
  logic                       out_is_base_r;
  logic [4:0]                 out_live_total_r;
  logic                       out_permit_r;

  logic                       accept;
  logic                       size_ok;
  logic [cba_pkg::COL_W-1:0]  col;
  logic [SUM_W-1:0]           bump_sum;
  logic [cba_pkg::END_W-1:0]  q_end;
  logic                       q_valid;
  cba_pkg::tok_t              tok [0:ENTRIES];
  cba_pkg::tok_t              exit_tok;

  assign accept   = start && !flight_r;
  assign busy     = flight_r;
  assign exit_tok = tok[ENTRIES];

  // Field decode shared by the ops.
  always_comb begin
    size_ok  = $onehot(in_size_cols) && (in_size_cols[4:0] == 5'd0);
    col      = cba_pkg::COL_W'(in_address[COLUMN_BITS-1:0]);
    bump_sum = SUM_W'(bump_r) + SUM_W'(in_size_cols);
    q_end    = cba_pkg::END_W'(col) + cba_pkg::END_W'(in_word_count);
    q_valid  = (in_word_count != 17'd0) && (q_end <= cba_pkg::END_W'(COL_COUNT));
  end

  // Accept-time checks and the item sent into the cell row.
  always_comb begin
    bump_nxt        = bump_r;
    last_nxt        = last_r;
    relinq_nxt      = relinq_r;
    used_nxt        = used_r;
    live_nxt        = live_r;
    hold_status_nxt = hold_status_r;
    hold_base_nxt   = hold_base_r;
    flight_nxt      = flight_r;
    inj_nxt         = '0;
    if (accept) begin
      flight_nxt      = 1'b1;
      hold_status_nxt = cba_pkg::ST_OK;
      hold_base_nxt   = 16'd0;
      inj_nxt.vld     = 1'b1;
      inj_nxt.col     = col;
      inj_nxt.size    = in_size_cols;
      inj_nxt.q_end   = q_end;
      inj_nxt.q_valid = q_valid;
      case (cba_pkg::op_t'(in_op))
        cba_pkg::OP_ALLOC: begin
          if (relinq_r) begin
            hold_status_nxt = cba_pkg::ST_PERMIT_GONE;
          end else if (!size_ok) begin
            hold_status_nxt = cba_pkg::ST_BAD_SIZE;
          end else if ((last_r != 10'd0) && (in_size_cols > last_r)) begin
            hold_status_nxt = cba_pkg::ST_SIZE_GREW;
          end else if (bump_sum > COL_COUNT) begin
            hold_status_nxt = cba_pkg::ST_OVERFLOW;
          end else if (used_r >= CNT_W'(ENTRIES)) begin
            hold_status_nxt = cba_pkg::ST_FULL;
          end else begin
            hold_base_nxt    = 16'(bump_r[COLUMN_BITS-1:0]);
            inj_nxt.do_alloc = 1'b1;
            inj_nxt.col      = cba_pkg::COL_W'(bump_r[COLUMN_BITS-1:0]);
            bump_nxt         = BP_W'(bump_sum);
            last_nxt         = in_size_cols;
            used_nxt         = used_r + CNT_W'(1);
            live_nxt         = live_r + CNT_W'(1);
          end
        end
        cba_pkg::OP_DEALLOC: begin
          if (!size_ok) begin
            hold_status_nxt = cba_pkg::ST_BAD_SIZE;
          end else begin
            inj_nxt.do_dealloc = 1'b1;
          end
        end
        cba_pkg::OP_QUERY: begin
          inj_nxt.do_query = 1'b1;
        end
        cba_pkg::OP_RELINQ: begin
          relinq_nxt = 1'b1;
        end
        cba_pkg::OP_CLEAR: begin
          inj_nxt.do_clear = 1'b1;
          bump_nxt         = '0;
          last_nxt         = 10'd0;
          relinq_nxt       = 1'b0;
          used_nxt         = '0;
          live_nxt         = '0;
        end
        default: begin
          // Unused op codes change nothing and report success.
          hold_status_nxt = cba_pkg::ST_OK;
        end
      endcase
    end else if (exit_tok.vld) begin
      flight_nxt = 1'b0;
      if (exit_tok.do_dealloc && exit_tok.f_match) begin
        live_nxt = live_r - CNT_W'(1);
      end
    end
  end

  // Final status once the item has passed every cell.
  always_comb begin
    out_status_nxt = hold_status_r;
    if (exit_tok.do_dealloc) begin
      if (exit_tok.f_match) begin
        out_status_nxt = cba_pkg::ST_OK;
      end else if (exit_tok.f_hit) begin
        out_status_nxt = cba_pkg::ST_MISMATCH;
      end else begin
        out_status_nxt = cba_pkg::ST_UNKNOWN;
      end
    end
  end

  // Control and scope state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flight_r    <= 1'b0;
      bump_r      <= '0;
      last_r      <= 10'd0;
      relinq_r    <= 1'b0;
      used_r      <= '0;
      live_r      <= '0;
      inj_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      flight_r    <= flight_nxt;
      bump_r      <= bump_nxt;
      last_r      <= last_nxt;
      relinq_r    <= relinq_nxt;
      used_r      <= used_nxt;
      live_r      <= live_nxt;
      inj_r       <= inj_nxt;
      out_valid_r <= exit_tok.vld;
    end
  end

  // Held results and the result registers.
  always_ff @(posedge clk) begin
    hold_status_r <= hold_status_nxt;
    hold_base_r   <= hold_base_nxt;
    if (exit_tok.vld) begin
      out_status_r     <= out_status_nxt;
      out_base_r       <= hold_base_r;
      out_in_live_r    <= exit_tok.f_live;
      out_in_any_r     <= exit_tok.f_any;
      out_is_base_r    <= exit_tok.f_base;
      out_live_total_r <= 5'(live_nxt);
      out_permit_r     <= relinq_r;
    end
  end

  // The row of table cells.
  assign tok[0] = inj_r;

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    cba_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (tok[k]),
      .tok_o (tok[k+1])
    );
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_grant_col    = out_base_r;
  assign out_in_live      = out_in_live_r;
  assign out_in_any       = out_in_any_r;
  assign out_is_live_base = out_is_base_r;
  assign out_live_total   = out_live_total_r;
  assign out_permit_gone  = out_permit_r;

  `CBA_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted item not marked busy")
  `CBA_ASSERT_SAME(a_result_idle, out_valid_r, !flight_r, "result shown while busy")
  `CBA_ASSERT_NEXT(a_exit_result, exit_tok.vld, out_valid_r, "finished item gave no result")
  `CBA_ASSERT_SAME(a_live_le_used, 1'b1, live_r <= used_r, "more live entries than used")
  `CBA_ASSERT_SAME(a_used_bound, 1'b1, used_r <= CNT_W'(ENTRIES), "slot count overrun")

endmodule
